>>> sv/first_match_xor_obfuscate_defines.svh
// assertion macros shared by the obfuscator rtl
`ifndef FIRST_MATCH_XOR_OBFUSCATE_DEFINES_SVH
`define FIRST_MATCH_XOR_OBFUSCATE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FMXO_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FMXO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/fmxo_pkg.sv
// shared constants, types and helpers of the obfuscator
package fmxo_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int MAX_KEY_DEF     = 16;
	localparam int BYTE_W          = 8;
	localparam int CFG_DW          = 64;
	localparam int CFG_IW          = 3;
	localparam int LEN_W           = 5;
	localparam int REG_BYTES       = 8;
	localparam int HELD_BYTES      = 16;

	typedef enum logic [CFG_IW-1:0] {
		REG_PAT_LO  = 3'd0,
		REG_PAT_HI  = 3'd1,
		REG_PAT_LEN = 3'd2,
		REG_KEY_LO  = 3'd3,
		REG_KEY_HI  = 3'd4,
		REG_KEY_LEN = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic              we;
		logic [CFG_IW-1:0] idx;
		logic [CFG_DW-1:0] data;
	} cfg_wr_t;

	// byte i of a two-register byte string, zero past the held bytes
	function automatic logic [BYTE_W-1:0] pick_byte(logic [CFG_DW-1:0] lo,
			logic [CFG_DW-1:0] hi, int i);
		logic [BYTE_W-1:0] r;
		r = '0;
		if (i < REG_BYTES) begin
			r = lo[BYTE_W*i +: BYTE_W];
		end else if (i < HELD_BYTES) begin
			r = hi[BYTE_W*(i-REG_BYTES) +: BYTE_W];
		end
		return r;
	endfunction

	// zero acts as one, above the maximum acts as the maximum
	function automatic int clamp_len(logic [LEN_W-1:0] v, int maxv);
		int r;
		r = int'(v);
		if (v == '0) begin
			r = 1;
		end else if (int'(v) > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage

>>> sv/fmxo_if.sv
// valid/ready stream interfaces for input bytes and result bytes
interface fmxo_in_if;
	import fmxo_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface fmxo_out_if;
	import fmxo_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              end_of_run;
	logic              match_found;

	modport source (output valid, output out_byte, output end_of_run, output match_found,
		input ready);
	modport sink (input valid, input out_byte, input end_of_run, input match_found,
		output ready);
endinterface

>>> sv/fmxo_key_expand.sv
// key registers and the sweep that unrolls the cyclic key over the window
module fmxo_key_expand
	import fmxo_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int MAX_KEY     = MAX_KEY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_wr_t           cfg,
	output logic [BYTE_W-1:0] ekey [MAX_PATTERN],
	output logic              busy
);

	localparam int IW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int KW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int KCW = $clog2(MAX_KEY + 1);

	logic [CFG_DW-1:0] key_lo_q, key_hi_q;
	logic [LEN_W-1:0]  key_len_q;
	logic [BYTE_W-1:0] ekey_q [MAX_PATTERN];
	logic [BYTE_W-1:0] keyb [MAX_KEY];
	logic [IW-1:0]     j_q;
	logic [KW-1:0]     kidx_q;
	logic              busy_q;
	logic [KCW-1:0]    klen;
	logic              key_wr;
	logic              wrap;

	always_comb begin
		for (int k = 0; k < MAX_KEY; k++) begin
			keyb[k] = pick_byte(key_lo_q, key_hi_q, k);
		end
	end

	assign klen   = KCW'(clamp_len(key_len_q, MAX_KEY));
	assign key_wr = cfg.we && (cfg.idx == REG_KEY_LO || cfg.idx == REG_KEY_HI ||
		cfg.idx == REG_KEY_LEN);
	assign wrap   = (KCW'(kidx_q) + KCW'(1)) == klen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q  <= '0;
			key_hi_q  <= '0;
			key_len_q <= LEN_W'(1);
			j_q       <= '0;
			kidx_q    <= '0;
			busy_q    <= 1'b0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				ekey_q[i] <= '0;
			end
		end else begin
			if (cfg.we) begin
				unique case (cfg_reg_t'(cfg.idx))
					REG_KEY_LO:  key_lo_q  <= cfg.data;
					REG_KEY_HI:  key_hi_q  <= cfg.data;
					REG_KEY_LEN: key_len_q <= cfg.data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (key_wr) begin
				// restart the sweep from the first window slot
				j_q    <= '0;
				kidx_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				ekey_q[j_q] <= keyb[kidx_q];
				kidx_q      <= wrap ? '0 : kidx_q + KW'(1);
				j_q         <= j_q + IW'(1);
				if (j_q == IW'(MAX_PATTERN - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign ekey = ekey_q;
	assign busy = busy_q;

endmodule

>>> sv/first_match_xor_obfuscate.sv
// first-match pattern obfuscator: delay line, window compare, key xor, result buffer
// a byte passes the input register, then the result buffer, before it leaves
// throughput: one byte per cycle while the run streams, the receiver is ready and no key unroll runs;
//   a final byte flushes the delay line, up to MAX_PATTERN results drained one per cycle while the receiver is ready
// a write to any key register starts a key unroll over all MAX_PATTERN slots, no byte steps meanwhile
// reset: control, pattern length and key length (1) cleared async; delay line needs no clear
`include "first_match_xor_obfuscate_defines.svh"
module first_match_xor_obfuscate
	import fmxo_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int MAX_KEY     = MAX_KEY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	fmxo_in_if.sink           feed,
	fmxo_out_if.source        result
);

	localparam int DEPTH = MAX_PATTERN;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// pattern configuration
	logic [CFG_DW-1:0] pat_lo_q, pat_hi_q;
	logic [LEN_W-1:0]  pat_len_q;

	// input register
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              fin_s1;

	// delay line state
	logic [BYTE_W-1:0] win_q [DEPTH];
	logic [CW-1:0]     fill_q;
	logic              matched_q;

	// result buffer, drained from slot 0
	logic [BYTE_W-1:0] obuf_q [DEPTH];
	logic [CW-1:0]     ocnt_q;
	logic              ofin_q;
	logic              omatch_q;

	// unrolled key
	cfg_wr_t           cfg;
	logic [BYTE_W-1:0] ekey [DEPTH];
	logic              kbusy;

	// step datapath
	logic [BYTE_W-1:0] pat [DEPTH];
	logic [BYTE_W-1:0] wnew [DEPTH];
	logic [BYTE_W-1:0] modw [DEPTH];
	logic [BYTE_W-1:0] rem [DEPTH];
	logic [DEPTH-1:0]  in_rng;
	logic [DEPTH-1:0]  pmatch;
	logic [IW-1:0]     jidx [DEPTH];
	logic [CW-1:0]     plen, nfill, base, emit, fill_next;
	logic              can_cmp, hit;

	// handshake
	logic              take, obuf_free, step, accept;

	assign cfg = '{we: cfg_we, idx: cfg_index, data: cfg_data};

	fmxo_key_expand #(
		.MAX_PATTERN (MAX_PATTERN),
		.MAX_KEY     (MAX_KEY)
	) u_key (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ekey   (ekey),
		.busy   (kbusy)
	);

	// flow control: the buffer takes a new batch once its last byte goes
	assign take      = result.valid && result.ready;
	assign obuf_free = (ocnt_q == '0) || (ocnt_q == CW'(1) && take);
	assign step      = v_s1 && !kbusy && obuf_free;
	assign feed.ready = !v_s1 || step;
	assign accept    = feed.valid && feed.ready;

	// pattern bytes, zero beyond the two registers
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			pat[i] = pick_byte(pat_lo_q, pat_hi_q, i);
		end
	end

	assign plen    = CW'(clamp_len(pat_len_q, DEPTH));
	assign nfill   = fill_q + CW'(1);
	assign can_cmp = !matched_q && (nfill >= plen);
	assign base    = nfill - plen;

	// per-slot insert, compare and xor; slot i holds pattern offset i - base
	always_comb begin
		logic [CW-1:0] rel;
		logic [CW:0]   sel;
		for (int i = 0; i < DEPTH; i++) begin
			wnew[i]   = (CW'(i) == fill_q) ? byte_s1 : win_q[i];
			in_rng[i] = (CW'(i) >= base) && (CW'(i) < nfill);
			rel       = CW'(i) - base;
			jidx[i]   = rel[IW-1:0];
			pmatch[i] = !in_rng[i] || (wnew[i] == pat[jidx[i]]);
		end
		hit = can_cmp && (&pmatch);
		for (int i = 0; i < DEPTH; i++) begin
			// zero bytes and bytes equal to their key byte stay as they are
			if (hit && in_rng[i] && wnew[i] != '0 && wnew[i] != ekey[jidx[i]]) begin
				modw[i] = wnew[i] ^ ekey[jidx[i]];
			end else begin
				modw[i] = wnew[i];
			end
		end
		// emitted bytes leave the front, the rest moves down
		for (int i = 0; i < DEPTH; i++) begin
			sel = {1'b0, CW'(i)} + {1'b0, emit};
			if (sel < (CW+1)'(DEPTH)) begin
				rem[i] = modw[sel[IW-1:0]];
			end else begin
				rem[i] = '0;
			end
		end
	end

	// final byte flushes everything, otherwise keep plen-1 bytes held
	always_comb begin
		if (fin_s1) begin
			emit = nfill;
		end else if (nfill >= plen) begin
			emit = nfill - plen + CW'(1);
		end else begin
			emit = '0;
		end
		fill_next = fin_s1 ? '0 : nfill - emit;
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_W'(1);
			v_s1      <= 1'b0;
			fill_q    <= '0;
			matched_q <= 1'b0;
			ocnt_q    <= '0;
			ofin_q    <= 1'b0;
			omatch_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PAT_LO:  pat_lo_q  <= cfg_data;
					REG_PAT_HI:  pat_hi_q  <= cfg_data;
					REG_PAT_LEN: pat_len_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (step) begin
				v_s1 <= 1'b0;
			end
			if (step) begin
				fill_q    <= fill_next;
				matched_q <= fin_s1 ? 1'b0 : (matched_q || hit);
				ocnt_q    <= emit;
				ofin_q    <= fin_s1;
				omatch_q  <= matched_q || hit;
			end else if (take) begin
				ocnt_q <= ocnt_q - CW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= feed.data_byte;
			fin_s1  <= feed.final_byte;
		end
		if (step) begin
			win_q  <= rem;
			obuf_q <= modw;
		end else if (take) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				obuf_q[i] <= obuf_q[i+1];
			end
		end
	end

	// result port: end of run only on the last byte of a flushed batch
	assign result.valid       = ocnt_q != '0;
	assign result.out_byte    = obuf_q[0];
	assign result.end_of_run  = ofin_q && (ocnt_q == CW'(1));
	assign result.match_found = ofin_q && (ocnt_q == CW'(1)) && omatch_q;

	`FMXO_ASSERT_IMPLIES(a_no_step_in_sweep, step, !kbusy, "byte stepped during key unroll")
	`FMXO_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_q < CW'(DEPTH), "delay line overfilled")
	`FMXO_ASSERT_NEXT(a_final_clears, step && fin_s1, fill_q == '0 && !matched_q,
		"run state kept after final byte")

endmodule

>>> dv/first_match_xor_obfuscate_tb.sv
// self-checking testbench for the first-match pattern obfuscator
module first_match_xor_obfuscate_tb;
	import fmxo_pkg::*;

	// clock, reset and pacing
	localparam int CLK_HALF         = 6;
	localparam int RESET_CYCLES     = 8;
	// a result leaves through the input register and result buffer, a flush drains up to a full window
	localparam int SETTLE_CYCLES    = 2 * MAX_PATTERN_DEF + 8;
	localparam int QUIET_LIMIT      = 2000;
	localparam int LONG_STALL       = 200;
	localparam int ITEMS_PER_MODE   = 120;
	localparam int ITEMS_PER_CONFIG = 30;
	localparam int IDLE_LOW_PCT     = 35;
	localparam int IDLE_HIGH_PCT    = 56;

	typedef enum int {
		IDLE_SRC_35_DST_56,
		IDLE_SRC_56_DST_35,
		IDLE_NONE
	} idle_mode_t;

	// one input transaction waiting for the driver
	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              fin;
		bit                drain;  // hold off until every expected result has come
	} feed_item_t;

	// one expected output transaction
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              end_of_run;
		logic              match_found;
	} out_rec_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	fmxo_in_if  feed_bus ();
	fmxo_out_if result_bus ();

	first_match_xor_obfuscate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.feed      (feed_bus),
		.result    (result_bus)
	);

	// predictor copy of the configuration
	logic [CFG_DW-1:0] pat_lo_m;
	logic [CFG_DW-1:0] pat_hi_m;
	logic [LEN_W-1:0]  pat_len_m;
	logic [CFG_DW-1:0] key_lo_m;
	logic [CFG_DW-1:0] key_hi_m;
	logic [LEN_W-1:0]  key_len_m;

	// predictor copy of the delay line, oldest byte at index 0
	logic [BYTE_W-1:0] delay_line [HELD_BYTES];
	int                line_fill;
	bit                found;

	out_rec_t   out_expect_q [$];
	feed_item_t feed_pending_q [$];
	feed_item_t feed_cur;
	out_rec_t   exp_rec;

	int         queued_cnt   = 0;
	int         accepted_cnt = 0;
	int         mismatch_cnt = 0;
	int         quiet_cycles = 0;
	bit         feed_took    = 1'b0;
	idle_mode_t idle_mode    = IDLE_SRC_35_DST_56;
	int         stall_req    = 0;
	int         stall_served = 0;
	int         stall_left   = 0;

	// clock
	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	// zero acts as one, anything past the maximum acts as the maximum
	function automatic int eff_len(logic [LEN_W-1:0] v, int maxv);
		if (v == '0)
			return 1;
		return (int'(v) > maxv) ? maxv : int'(v);
	endfunction

	// byte i of a low/high register pair, i below 16
	function automatic logic [BYTE_W-1:0] byte_at(logic [CFG_DW-1:0] lo, logic [CFG_DW-1:0] hi,
			int i);
		logic [2*CFG_DW-1:0] both;
		both = {hi, lo};
		return both[BYTE_W*i +: BYTE_W];
	endfunction

	// advance the delay line by one accepted byte and queue the results it releases
	task automatic obfuscate_step(logic [BYTE_W-1:0] b, logic fin);
		int                plen;
		int                klen;
		int                base;
		int                emit;
		int                keep;
		bit                hit;
		logic [BYTE_W-1:0] kb;
		logic [BYTE_W-1:0] v;
		out_rec_t          rec;
		plen = eff_len(pat_len_m, MAX_PATTERN_DEF);
		klen = eff_len(key_len_m, MAX_KEY_DEF);
		if (line_fill >= MAX_PATTERN_DEF)
			line_fill = MAX_PATTERN_DEF - 1;
		delay_line[line_fill] = b;
		line_fill++;

		// only the first occurrence in a run is obfuscated
		if (!found && line_fill >= plen) begin
			base = line_fill - plen;
			hit = 1'b1;
			for (int j = 0; j < plen; j++) begin
				if (delay_line[base+j] != byte_at(pat_lo_m, pat_hi_m, j))
					hit = 1'b0;
			end
			if (hit) begin
				for (int j = 0; j < plen; j++) begin
					kb = byte_at(key_lo_m, key_hi_m, j % klen);
					v = delay_line[base+j];
					// zero bytes and bytes equal to their key byte stay as they are
					if (v != '0 && v != kb)
						delay_line[base+j] = v ^ kb;
				end
				found = 1'b1;
			end
		end

		// a final byte flushes everything, otherwise keep plen-1 bytes back
		if (fin)
			emit = line_fill;
		else if (line_fill >= plen)
			emit = line_fill - plen + 1;
		else
			emit = 0;

		for (int k = 0; k < emit; k++) begin
			rec.out_byte    = delay_line[k];
			rec.end_of_run  = fin && (k == emit - 1);
			rec.match_found = rec.end_of_run && found;
			out_expect_q.push_back(rec);
		end

		keep = line_fill - emit;
		for (int k = 0; k < keep; k++)
			delay_line[k] = delay_line[k+emit];
		for (int k = keep; k < HELD_BYTES; k++)
			delay_line[k] = '0;
		line_fill = keep;

		if (fin) begin
			line_fill = 0;
			found = 1'b0;
		end
	endtask

	// register write at the next falling edge, predictor copy follows along
	task automatic cfg_write(cfg_reg_t idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PAT_LO: begin
				pat_lo_m = val;
			end
			REG_PAT_HI: begin
				pat_hi_m = val;
			end
			REG_PAT_LEN: begin
				pat_len_m = val[LEN_W-1:0];
			end
			REG_KEY_LO: begin
				key_lo_m = val;
			end
			REG_KEY_HI: begin
				key_hi_m = val;
			end
			REG_KEY_LEN: begin
				key_len_m = val[LEN_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void queue_byte(logic [BYTE_W-1:0] d, logic fin, bit drain);
		feed_item_t it;
		it.data  = d;
		it.fin   = fin;
		it.drain = drain;
		feed_pending_q.push_back(it);
		queued_cnt++;
	endfunction

	// all queued bytes taken, all results seen, then let held bytes settle inside the block
	task automatic wait_idle();
		do
			@(negedge clk);
		while (accepted_cnt != queued_cnt || out_expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// wide register value, the extremes now and then
	function automatic logic [CFG_DW-1:0] wide_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// length value with junk in the unused upper bits
	function automatic logic [CFG_DW-1:0] len_value();
		logic [CFG_DW-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v[LEN_W-1:0] = '0;
			1: v[LEN_W-1:0] = LEN_W'(16);
			2: v[LEN_W-1:0] = LEN_W'($urandom_range(17, 31));
			3: v[LEN_W-1:0] = LEN_W'(1);
			default: v[LEN_W-1:0] = LEN_W'($urandom_range(1, 6));
		endcase
		return v;
	endfunction

	task automatic pick_config();
		wait_idle();
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_PAT_LO, wide_value());
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_PAT_HI, wide_value());
		cfg_write(REG_PAT_LEN, len_value());
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_KEY_LO, wide_value());
		if ($urandom_range(0, 4) != 0)
			cfg_write(REG_KEY_HI, wide_value());
		cfg_write(REG_KEY_LEN, len_value());
	endtask

	// one run built mostly from the pattern: whole copies, broken prefixes, loose pattern
	// bytes and noise; returns the number of bytes queued
	function automatic int gen_run(bit closed, bit force_drain);
		int plen;
		int len;
		int made;
		int r;
		int cut;
		int first_idx;
		plen = eff_len(pat_len_m, MAX_PATTERN_DEF);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 20);
		made = 0;
		first_idx = feed_pending_q.size();
		while (made < len) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				for (int j = 0; j < plen; j++)
					queue_byte(byte_at(pat_lo_m, pat_hi_m, j), 1'b0, 1'b0);
				made += plen;
			end else if (r < 35) begin
				// prefix of the pattern, then one flipped bit
				cut = $urandom_range(0, plen - 1);
				for (int j = 0; j < cut; j++)
					queue_byte(byte_at(pat_lo_m, pat_hi_m, j), 1'b0, 1'b0);
				queue_byte(byte_at(pat_lo_m, pat_hi_m, cut) ^ (8'h01 << $urandom_range(0, 7)),
					1'b0, 1'b0);
				made += cut + 1;
			end else if (r < 75) begin
				queue_byte(byte_at(pat_lo_m, pat_hi_m, $urandom_range(0, plen - 1)), 1'b0, 1'b0);
				made++;
			end else begin
				queue_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
				made++;
			end
		end
		// nothing is consumed before time advances, so the flags can be patched in place
		feed_pending_q[$].fin = closed;
		feed_pending_q[first_idx].drain = force_drain || ($urandom_range(0, 11) == 0);
		return made;
	endfunction

	// sender pacing for the current phase, a drain item waits for all results
	function automatic bit sender_go();
		if (feed_pending_q[0].drain && out_expect_q.size() != 0)
			return 1'b0;
		case (idle_mode)
			IDLE_SRC_35_DST_56: return $urandom_range(0, 99) >= IDLE_LOW_PCT;
			IDLE_SRC_56_DST_35: return $urandom_range(0, 99) >= IDLE_HIGH_PCT;
			default: return 1'b1;
		endcase
	endfunction

	// input driver: new transaction at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (!feed_bus.valid || feed_took) begin
			if (arst_n && feed_pending_q.size() != 0 && sender_go()) begin
				feed_cur = feed_pending_q.pop_front();
				feed_bus.valid      <= 1'b1;
				feed_bus.data_byte  <= feed_cur.data;
				feed_bus.final_byte <= feed_cur.fin;
			end else begin
				// junk payload while idle
				feed_bus.valid      <= 1'b0;
				feed_bus.data_byte  <= BYTE_W'($urandom_range(0, 255));
				feed_bus.final_byte <= 1'($urandom_range(0, 1));
			end
		end
		feed_took = 1'b0;
	end

	// result ready: long hold-off on request, otherwise paced by the phase
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_bus.ready <= 1'b0;
		end else if (stall_served != stall_req) begin
			stall_served++;
			stall_left = LONG_STALL - 1;
			result_bus.ready <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_SRC_35_DST_56: result_bus.ready <= $urandom_range(0, 99) >= IDLE_HIGH_PCT;
				IDLE_SRC_56_DST_35: result_bus.ready <= $urandom_range(0, 99) >= IDLE_LOW_PCT;
				default: result_bus.ready <= 1'b1;
			endcase
		end
	end

	// monitor: predict on every input transaction, check every output transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (feed_bus.valid && feed_bus.ready) begin
				feed_took = 1'b1;
				accepted_cnt++;
				obfuscate_step(feed_bus.data_byte, feed_bus.final_byte);
			end
			if (result_bus.valid && result_bus.ready) begin
				if (out_expect_q.size() == 0) begin
					$error("unexpected result: out_byte %02h end_of_run %0b match_found %0b",
						result_bus.out_byte, result_bus.end_of_run, result_bus.match_found);
					mismatch_cnt++;
				end else begin
					exp_rec = out_expect_q.pop_front();
					if (exp_rec.out_byte !== result_bus.out_byte) begin
						$error("out_byte: expected %02h, got %02h",
							exp_rec.out_byte, result_bus.out_byte);
						mismatch_cnt++;
					end
					if (exp_rec.end_of_run !== result_bus.end_of_run) begin
						$error("end_of_run: expected %0b, got %0b",
							exp_rec.end_of_run, result_bus.end_of_run);
						mismatch_cnt++;
					end
					if (exp_rec.match_found !== result_bus.match_found) begin
						$error("match_found: expected %0b, got %0b",
							exp_rec.match_found, result_bus.match_found);
						mismatch_cnt++;
					end
				end
			end
			if ((feed_bus.valid && feed_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// watchdog on cycles without any transaction
	always @(negedge clk) begin
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// stimulus
	initial begin
		int made;
		int seg;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_PAT_LO;
		cfg_data            = '0;
		feed_bus.valid      = 1'b0;
		feed_bus.data_byte  = '0;
		feed_bus.final_byte = 1'b0;
		result_bus.ready    = 1'b0;

		// predictor reset state
		pat_lo_m  = '0;
		pat_hi_m  = '0;
		pat_len_m = LEN_W'(1);
		key_lo_m  = '0;
		key_hi_m  = '0;
		key_len_m = LEN_W'(1);
		for (int k = 0; k < HELD_BYTES; k++)
			delay_line[k] = '0;
		line_fill = 0;
		found     = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(negedge clk);

		// pattern 12 00 ff: zero byte and key-equal byte inside the match stay put
		cfg_write(REG_PAT_LO, 64'h0000_0000_00FF_0012);
		cfg_write(REG_PAT_HI, 64'h0);
		cfg_write(REG_PAT_LEN, 64'd3);
		cfg_write(REG_KEY_LO, 64'h0000_0000_0000_5A12);
		cfg_write(REG_KEY_HI, 64'h0);
		cfg_write(REG_KEY_LEN, 64'd2);
		// second occurrence in the same run must pass untouched
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'h12, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'h12, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b1, 1'b0);
		// run shorter than the pattern, flushed as is
		queue_byte(8'h12, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b1, 1'b0);
		// two bytes held, then the length drops to zero (acts as one) mid run
		queue_byte(8'h12, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		wait_idle();
		cfg_write(REG_PAT_LEN, 64'd0);
		queue_byte(8'h12, 1'b1, 1'b0);
		wait_idle();

		// lengths above the maximum act as sixteen: full window match, sixteen results at once
		cfg_write(REG_PAT_LO, 64'h8877_6655_4433_2211);
		cfg_write(REG_PAT_HI, 64'h00FF_EEDD_CCBB_AA99);
		cfg_write(REG_PAT_LEN, 64'd31);
		cfg_write(REG_KEY_LO, 64'h0102_0304_0506_0711);
		cfg_write(REG_KEY_HI, 64'hF0E0_D0C0_B0A0_9080);
		cfg_write(REG_KEY_LEN, 64'd20);
		for (int j = 0; j < MAX_PATTERN_DEF; j++)
			queue_byte(byte_at(pat_lo_m, pat_hi_m, j), j == MAX_PATTERN_DEF - 1, 1'b0);

		// random runs under the three pacing phases
		for (int m = 0; m < 3; m++) begin
			made = 0;
			while (made < ITEMS_PER_MODE) begin
				pick_config();
				idle_mode = idle_mode_t'(m);
				// long receiver hold-off while the sender keeps offering
				if (idle_mode == IDLE_NONE && made == 0)
					stall_req++;
				seg = 0;
				while (seg < ITEMS_PER_CONFIG)
					seg += gen_run(1'b1, m == 1 && made == 0 && seg == 0);
				// sometimes leave a run open so the next settings apply mid run
				if ($urandom_range(0, 3) == 0)
					seg += gen_run(1'b0, 1'b0);
				made += seg;
			end
		end
		// close whatever is still held
		void'(gen_run(1'b1, 1'b0));

		wait_idle();
		if (mismatch_cnt == 0 && out_expect_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
+incdir+sv
sv/fmxo_pkg.sv
sv/fmxo_if.sv
sv/fmxo_key_expand.sv
sv/first_match_xor_obfuscate.sv
dv/first_match_xor_obfuscate_tb.sv
